### rtl/pcaf_pkg.sv
// ----------------------------------------------------------------------------
// pcaf_pkg
// Shared types and constants of the configuration-access filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcaf_pkg;

  localparam int TABLE_DEPTH = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_END   = 1'd1;

  localparam logic [7:0] BUS_START_RST = 8'h00;
  localparam logic [7:0] BUS_END_RST   = 8'hff;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_WRITE  = 2'd3;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_RANGE        = 3'd1;
  localparam logic [2:0] ST_NOT_IN_TABLE = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE     = 3'd3;
  localparam logic [2:0] ST_FULL         = 3'd4;

  localparam logic [2:0] SZ_BYTE = 3'd1;
  localparam logic [2:0] SZ_HALF = 3'd2;
  localparam logic [2:0] SZ_WORD = 3'd4;

  localparam logic [31:0] MASK_BYTE = 32'h0000_00ff;
  localparam logic [31:0] MASK_HALF = 32'h0000_ffff;
  localparam logic [31:0] MASK_WORD = 32'hffff_ffff;

  localparam int TRIPLE_W = 16;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  bus_number;
    logic [5:0]  device_number;
    logic [3:0]  function_number;
    logic [12:0] register_offset;
    logic [2:0]  access_size;
    logic [31:0] write_value;
    logic [31:0] old_dword;
    logic [15:0] entry_triple;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        use_root_window;
    logic [27:0] dword_offset;
    logic [31:0] read_result;
    logic [31:0] write_dword;
    logic        do_write;
  } out_rsp_t;

  typedef struct packed {
    logic                range_bad;
    logic                triple_zero;
    logic [TRIPLE_W-1:0] triple;
  } chk_t;

endpackage

`default_nettype wire

### rtl/pcaf_ram.sv
// ----------------------------------------------------------------------------
// pcaf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/pcaf_access.sv
// ----------------------------------------------------------------------------
// pcaf_access
// Range checks, triple build, ECAM offset and read extract / write merge.
// ----------------------------------------------------------------------------
`default_nettype none

module pcaf_access (
  input  wire logic               [7:0] win_start,
  input  wire logic               [7:0] win_end,
  input  wire pcaf_pkg::in_req_t        req,
  input  wire logic                     hit,
  output pcaf_pkg::chk_t                chk,
  output pcaf_pkg::out_rsp_t            rsp
);

  logic        is_write;
  logic        size_ok;
  logic [4:0]  sh;
  logic [31:0] mask;
  logic [7:0]  bus_rel;
  logic [31:0] rd_data;
  logic [31:0] wr_data;

  always_comb begin
    chk.range_bad = (req.bus_number < win_start) || (req.bus_number > win_end) ||
                    req.device_number[5] || req.function_number[3] ||
                    req.register_offset[12];
    chk.triple = {req.bus_number, req.device_number[4:0], req.function_number[2:0]};
    chk.triple_zero = (chk.triple == '0);
  end

  always_comb begin
    is_write = (req.command == pcaf_pkg::CMD_WRITE);
    size_ok  = (req.access_size == pcaf_pkg::SZ_BYTE) ||
               (req.access_size == pcaf_pkg::SZ_HALF) ||
               (req.access_size == pcaf_pkg::SZ_WORD);
    sh       = {req.register_offset[1:0], 3'b000};
    bus_rel  = req.bus_number - win_start;

    priority if (req.access_size == pcaf_pkg::SZ_WORD) begin
      mask = pcaf_pkg::MASK_WORD;
    end else if (req.access_size == pcaf_pkg::SZ_HALF) begin
      mask = pcaf_pkg::MASK_HALF;
    end else begin
      mask = pcaf_pkg::MASK_BYTE;
    end

    if (req.access_size == pcaf_pkg::SZ_WORD) begin
      rd_data = req.old_dword;
      wr_data = req.write_value;
    end else begin
      rd_data = (req.old_dword >> sh) & mask;
      wr_data = (req.old_dword & ~(mask << sh)) | ((req.write_value & mask) << sh);
    end
  end

  always_comb begin
    rsp = '0;
    priority if (chk.range_bad) begin
      rsp.status = pcaf_pkg::ST_RANGE;
    end else if (!(chk.triple_zero || hit)) begin
      rsp.status = pcaf_pkg::ST_NOT_IN_TABLE;
    end else if (!size_ok) begin
      rsp.status = pcaf_pkg::ST_BAD_SIZE;
    end else begin
      rsp.status = pcaf_pkg::ST_OK;
    end

    if (rsp.status == pcaf_pkg::ST_OK) begin
      rsp.use_root_window = chk.triple_zero;
      rsp.dword_offset    = {bus_rel, req.device_number[4:0], req.function_number[2:0],
                             req.register_offset[11:2], 2'b00};
      if (is_write) begin
        rsp.write_dword = wr_data;
        rsp.do_write    = 1'b1;
      end else begin
        rsp.read_result = rd_data;
      end
    end else if (!is_write) begin
      rsp.read_result = pcaf_pkg::MASK_WORD;
    end
  end

endmodule

`default_nettype wire

### rtl/pcaf_ctrl.sv
// ----------------------------------------------------------------------------
// pcaf_ctrl
// Request sequencer: table clear/append, allowlist scan through the RAM,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcaf_ctrl #(
  parameter int TABLE_DEPTH = pcaf_pkg::TABLE_DEPTH
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         start,
  input  wire pcaf_pkg::in_req_t                            in_req,
  output logic                                              busy,
  output logic                                              out_valid,
  output pcaf_pkg::out_rsp_t                                out_rsp,
  output pcaf_pkg::in_req_t                                 acc_req,
  output logic                                              acc_hit,
  input  wire pcaf_pkg::chk_t                               acc_chk,
  input  wire pcaf_pkg::out_rsp_t                           acc_rsp,
  output logic                                              ram_we,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
  output logic [pcaf_pkg::TRIPLE_W-1:0]                     ram_wdata,
  output logic                                              ram_re,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
  input  wire logic [pcaf_pkg::TRIPLE_W-1:0]                ram_rdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN
  } state_t;

  state_t             state_r, state_nxt;
  pcaf_pkg::in_req_t  req_r, req_nxt;
  pcaf_pkg::out_rsp_t rsp_r, rsp_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    rsp_nxt   = rsp_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    valid_nxt = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = in_req.entry_triple;
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];
    acc_hit   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          unique case (in_req.command)
            pcaf_pkg::CMD_CLEAR: begin
              count_nxt      = '0;
              rsp_nxt        = '0;
              rsp_nxt.status = pcaf_pkg::ST_OK;
              valid_nxt      = 1'b1;
            end
            pcaf_pkg::CMD_APPEND: begin
              rsp_nxt = '0;
              if (count_r < CW'(TABLE_DEPTH)) begin
                ram_we         = 1'b1;
                count_nxt      = count_r + CW'(1);
                rsp_nxt.status = pcaf_pkg::ST_OK;
              end else begin
                rsp_nxt.status = pcaf_pkg::ST_FULL;
              end
              valid_nxt = 1'b1;
            end
            pcaf_pkg::CMD_READ, pcaf_pkg::CMD_WRITE: begin
              state_nxt = S_CHECK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (acc_chk.range_bad || acc_chk.triple_zero || (count_r == '0)) begin
          rsp_nxt   = acc_rsp;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          idx_nxt   = CW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        acc_hit = (ram_rdata == acc_chk.triple);
        if (acc_hit || (idx_r == count_r)) begin
          rsp_nxt   = acc_rsp;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_re  = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
    idx_r <= idx_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;
  assign acc_req   = req_r;

endmodule

`default_nettype wire

### rtl/pcie_config_access_filter.sv
// ----------------------------------------------------------------------------
// pcie_config_access_filter
// Configuration-access filter with a bus/device/function allowlist in RAM.
// ----------------------------------------------------------------------------
// clear and append: result strobe in the cycle after the request, busy stays low
// read and write: decided in S_CHECK without a scan when out of range, for 0/0/0
//   or with an empty table, else entries are compared in S_SCAN, one RAM read each
// worst case: all entries of a full 64-entry table are compared
// results are strobed for one cycle and cannot be stalled
// reset: window 0..255, table empty; table RAM contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module pcie_config_access_filter #(
  parameter int TABLE_DEPTH = pcaf_pkg::TABLE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire pcaf_pkg::in_req_t                   in_req,
  output logic                                     out_valid,
  output pcaf_pkg::out_rsp_t                       out_rsp,
  input  wire logic                                cfg_we,
  input  wire logic [pcaf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pcaf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [7:0] win_start_r;
  logic [7:0] win_end_r;

  pcaf_pkg::in_req_t               acc_req;
  pcaf_pkg::chk_t                  acc_chk;
  pcaf_pkg::out_rsp_t              acc_rsp;
  logic                            acc_hit;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [pcaf_pkg::TRIPLE_W-1:0]   ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [pcaf_pkg::TRIPLE_W-1:0]   ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= pcaf_pkg::BUS_START_RST;
      win_end_r   <= pcaf_pkg::BUS_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcaf_pkg::CFG_BUS_START: win_start_r <= cfg_wdata;
        pcaf_pkg::CFG_BUS_END:   win_end_r   <= cfg_wdata;
        default: begin
          win_start_r <= win_start_r;
        end
      endcase
    end
  end

  pcaf_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .acc_req   (acc_req),
    .acc_hit   (acc_hit),
    .acc_chk   (acc_chk),
    .acc_rsp   (acc_rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  pcaf_access u_access (
    .win_start (win_start_r),
    .win_end   (win_end_r),
    .req       (acc_req),
    .hit       (acc_hit),
    .chk       (acc_chk),
    .rsp       (acc_rsp)
  );

  pcaf_ram #(
    .WIDTH(pcaf_pkg::TRIPLE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // table updates and scans never overlap
  a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> !ram_we)
    else $error("table write during scan");

  a_table_cmd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_req.command == pcaf_pkg::CMD_CLEAR) ||
                        (in_req.command == pcaf_pkg::CMD_APPEND)))
    |=> (out_valid && !busy))
    else $error("table request did not complete in one cycle");

  a_access_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_req.command == pcaf_pkg::CMD_READ) ||
                        (in_req.command == pcaf_pkg::CMD_WRITE)))
    |=> (busy && !out_valid))
    else $error("access request did not enter the check");

  a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status != pcaf_pkg::ST_OK))
    |-> (!out_rsp.do_write && (out_rsp.dword_offset == '0) && !out_rsp.use_root_window))
    else $error("rejected request carries a target");

endmodule

`default_nettype wire
